/* hw/rtl/csc_pkg.sv */
// shared types and constants for the crt sieve combiner
// command and status structs between controller and datapath; no dependencies
`timescale 1ns / 1ps

package csc_pkg;

  // fixed field widths of the item interface
  localparam int MOD_W = 16;
  localparam int SOL_W = 63;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOSOL = 2'd1,
    ST_OVF   = 2'd2
  } csc_status_e;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture a new input item
    logic rem_step;    // one bit of the shared remainder unit
    logic set_a;       // keep required residue, start reducing the solution
    logic new_commit;  // open a new system with residue and modulus
    logic set_r;       // keep solution mod n, start reducing the product
    logic set_pm;      // keep product mod n, set up sieve and multiplier
    logic sieve_step;  // advance candidate by one product
    logic mul_step;    // one bit of product times modulus
    logic commit;      // overflow check and state update
    logic set_nosol;   // flag no match within one modulus of steps
    logic out_load;    // move result into the output register
  } csc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic new_sys;  // first flag set or no system open yet
    logic match;    // running residue equals the required one
    logic last_k;   // this is the last sieve step within one modulus
  } csc_sts_t;

endpackage

/* hw/rtl/crt_sieve_combiner_top.sv */
// top level of the crt sieve combiner: stream ports, controller and datapath
// depends on csc_pkg, csc_ctrl and csc_datapath
`timescale 1ns / 1ps

// Combines a system of congruences x = (-offset) mod modulus, one congruence per
// input item, and returns the running solution, the product of the moduli and a
// status for every item. One item is worked on at a time; the block takes a new
// item as soon as the previous result sits in the output register. An item that
// opens a new system (first set, or none open yet) only reduces its offset. Any
// other item also reduces the solution and the product modulo its modulus, then
// steps the sieve until the congruence holds, for at most one modulus of steps; a
// bit-serial remainder unit (three reductions, one bit per cycle, up to 63 bits
// each) and the one-step-per-cycle sieve loop set how long such an item takes.
// Status 1 means no match within one modulus of steps, status 2 that the solution
// or product would pass 63 bits; in both cases the state is kept.
// Modulus and offset are masked to MOD_BITS bits, and a zero modulus counts as one.
module crt_sieve_combiner_top #(
  parameter int MOD_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [31:0]  s_axis_tdata_i,   // modulus[15:0], offset[31:16]
  input  logic         s_axis_tuser_i,   // first
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o,   // solution[62:0], combined_modulus[125:63], zero fill
  output logic [1:0]   m_axis_tuser_o    // status
);
  import csc_pkg::*;

  csc_cmd_t         cmd;
  csc_sts_t         sts;
  logic [SOL_W-1:0] solution;
  logic [SOL_W-1:0] combined_modulus;
  logic [1:0]       status;

  // sequencer: handshakes and the order of the work phases
  csc_ctrl #(
    .MOD_BITS (MOD_BITS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // arithmetic, running state and output register
  csc_datapath #(
    .MOD_BITS (MOD_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .modulus_i          (s_axis_tdata_i[MOD_W-1:0]),
    .offset_i           (s_axis_tdata_i[2*MOD_W-1:MOD_W]),
    .first_i            (s_axis_tuser_i),
    .solution_o         (solution),
    .combined_modulus_o (combined_modulus),
    .status_o           (status)
  );

  // pack result item, zero fill to whole bytes
  assign m_axis_tdata_o = {2'b00, combined_modulus, solution};
  assign m_axis_tuser_o = status;

endmodule

/* hw/rtl/csc_ctrl.sv */
// sequencing controller for the crt sieve combiner
// depends on csc_pkg for the command and status structs
`timescale 1ns / 1ps

module csc_ctrl #(
  parameter int MOD_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  input  csc_pkg::csc_sts_t sts_i,
  output csc_pkg::csc_cmd_t cmd_o
);
  import csc_pkg::*;

  localparam int NB    = (MOD_BITS < MOD_W) ? MOD_BITS : MOD_W;
  localparam int CNT_W = $clog2(SOL_W);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_RED_P  = 11'b00000000010,
    S_SET_A  = 11'b00000000100,
    S_RED_S  = 11'b00000001000,
    S_SET_R  = 11'b00000010000,
    S_RED_M  = 11'b00000100000,
    S_SET_PM = 11'b00001000000,
    S_SIEVE  = 11'b00010000000,
    S_MUL    = 11'b00100000000,
    S_COMMIT = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } csc_state_e;

  csc_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             m_valid_q, m_valid_d;

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = m_valid_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = CNT_W'(NB - 1);
          state_d    = S_RED_P;
        end
      end
      S_RED_P: begin
        cmd_o.rem_step = 1'b1;
        cnt_d          = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_SET_A;
        end
      end
      S_SET_A: begin
        cmd_o.set_a = 1'b1;
        if (sts_i.new_sys) begin
          cmd_o.new_commit = 1'b1;
          state_d          = S_DONE;
        end else begin
          cnt_d   = CNT_W'(SOL_W - 1);
          state_d = S_RED_S;
        end
      end
      S_RED_S: begin
        cmd_o.rem_step = 1'b1;
        cnt_d          = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_SET_R;
        end
      end
      S_SET_R: begin
        cmd_o.set_r = 1'b1;
        cnt_d       = CNT_W'(SOL_W - 1);
        state_d     = S_RED_M;
      end
      S_RED_M: begin
        cmd_o.rem_step = 1'b1;
        cnt_d          = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_SET_PM;
        end
      end
      S_SET_PM: begin
        cmd_o.set_pm = 1'b1;
        state_d      = S_SIEVE;
      end
      S_SIEVE: begin
        if (sts_i.match) begin
          cnt_d   = CNT_W'(NB - 1);
          state_d = S_MUL;
        end else if (sts_i.last_k) begin
          cmd_o.set_nosol = 1'b1;
          state_d         = S_DONE;
        end else begin
          cmd_o.sieve_step = 1'b1;
        end
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        cnt_d          = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!m_valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.out_load) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

endmodule

/* hw/rtl/csc_datapath.sv */
// datapath of the crt sieve combiner: remainder unit, sieve, multiplier, state
// depends on csc_pkg; driven by csc_ctrl through csc_cmd_t
`timescale 1ns / 1ps

module csc_datapath #(
  parameter int MOD_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  csc_pkg::csc_cmd_t        cmd_i,
  output csc_pkg::csc_sts_t        sts_o,
  input  logic [csc_pkg::MOD_W-1:0] modulus_i,
  input  logic [csc_pkg::MOD_W-1:0] offset_i,
  input  logic                     first_i,
  output logic [csc_pkg::SOL_W-1:0] solution_o,
  output logic [csc_pkg::SOL_W-1:0] combined_modulus_o,
  output logic [1:0]               status_o
);
  import csc_pkg::*;

  localparam int NB    = (MOD_BITS < MOD_W) ? MOD_BITS : MOD_W;
  localparam int ACC_W = SOL_W + NB;

  // architectural state
  logic [SOL_W-1:0] sol_q, sol_d;
  logic [SOL_W-1:0] prod_q, prod_d;
  logic             started_q, started_d;

  // per-item working registers
  logic [NB-1:0]    n_q, a_q, r_q, pm_q, rem_q, k_q, msh_q;
  logic             first_q;
  logic [SOL_W-1:0] sh_q, cand_q;
  logic             ovf_q;
  logic [ACC_W-1:0] acc_q;
  csc_status_e      st_q;

  logic [SOL_W-1:0] out_sol_q, out_prod_q;
  csc_status_e      out_st_q;

  logic [NB-1:0]    mod_m, n_in;
  logic [NB:0]      rem_t, r_t;
  logic [NB-1:0]    rem_nxt, r_nxt, a_val;
  logic [SOL_W:0]   cand_sum;
  logic             mul_ovf;

  assign mod_m = modulus_i[NB-1:0];
  assign n_in  = (mod_m == '0) ? NB'(1) : mod_m;

  // one bit of restoring remainder: value stays below n
  assign rem_t   = {rem_q, sh_q[SOL_W-1]};
  assign rem_nxt = (rem_t >= {1'b0, n_q}) ? NB'(rem_t - {1'b0, n_q}) : rem_t[NB-1:0];
  assign a_val   = (rem_q == '0) ? '0 : n_q - rem_q;

  // next residue of the sieve, both terms below n
  assign r_t   = {1'b0, r_q} + {1'b0, pm_q};
  assign r_nxt = (r_t >= {1'b0, n_q}) ? NB'(r_t - {1'b0, n_q}) : r_t[NB-1:0];

  assign cand_sum = {1'b0, cand_q} + {1'b0, prod_q};
  assign mul_ovf  = (acc_q[ACC_W-1:SOL_W] != '0);

  assign sts_o.new_sys = first_q || !started_q;
  assign sts_o.match   = (r_q == a_q);
  assign sts_o.last_k  = (k_q == (n_q - NB'(1)));

  always_comb begin
    sol_d     = sol_q;
    prod_d    = prod_q;
    started_d = started_q;
    if (cmd_i.new_commit) begin
      sol_d     = SOL_W'(a_val);
      prod_d    = SOL_W'(n_q);
      started_d = 1'b1;
    end else if (cmd_i.commit && !ovf_q && !mul_ovf) begin
      sol_d  = cand_q;
      prod_d = acc_q[SOL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sol_q     <= '0;
      prod_q    <= SOL_W'(1);
      started_q <= 1'b0;
    end else begin
      sol_q     <= sol_d;
      prod_q    <= prod_d;
      started_q <= started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q     <= n_in;
      first_q <= first_i;
      sh_q    <= {offset_i[NB-1:0], {(SOL_W - NB){1'b0}}};
      rem_q   <= '0;
    end
    if (cmd_i.rem_step) begin
      rem_q <= rem_nxt;
      sh_q  <= {sh_q[SOL_W-2:0], 1'b0};
    end
    if (cmd_i.set_a) begin
      a_q   <= a_val;
      sh_q  <= sol_q;
      rem_q <= '0;
    end
    if (cmd_i.set_r) begin
      r_q   <= rem_q;
      sh_q  <= prod_q;
      rem_q <= '0;
    end
    if (cmd_i.set_pm) begin
      pm_q   <= rem_q;
      cand_q <= sol_q;
      ovf_q  <= 1'b0;
      k_q    <= '0;
      acc_q  <= '0;
      msh_q  <= n_q;
    end
    if (cmd_i.sieve_step) begin
      r_q    <= r_nxt;
      cand_q <= cand_sum[SOL_W-1:0];
      ovf_q  <= ovf_q | cand_sum[SOL_W];
      k_q    <= k_q + NB'(1);
    end
    if (cmd_i.mul_step) begin
      acc_q <= {acc_q[ACC_W-2:0], 1'b0} + (msh_q[NB-1] ? ACC_W'(prod_q) : '0);
      msh_q <= {msh_q[NB-2:0], 1'b0};
    end
    if (cmd_i.new_commit) begin
      st_q <= ST_OK;
    end else if (cmd_i.set_nosol) begin
      st_q <= ST_NOSOL;
    end else if (cmd_i.commit) begin
      st_q <= (ovf_q || mul_ovf) ? ST_OVF : ST_OK;
    end
    if (cmd_i.out_load) begin
      out_sol_q  <= sol_q;
      out_prod_q <= prod_q;
      out_st_q   <= st_q;
    end
  end

  assign solution_o         = out_sol_q;
  assign combined_modulus_o = out_prod_q;
  assign status_o           = out_st_q;

endmodule
